[rtl/stereo_quadratic_dither_24bit_top_macros.svh]
// Assertion macros shared by the dither requantizer modules.
// Expects clock and reset signals in the scope of each use.
`ifndef STEREO_QUADRATIC_DITHER_24BIT_TOP_MACROS_SVH
`define STEREO_QUADRATIC_DITHER_24BIT_TOP_MACROS_SVH

// condition holds at every edge outside reset
`define SQD_AST_HOLD(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SQD_AST_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SQD_AST_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/sqd_pkg.sv]
// Package for the stereo quadratic dither requantizer.
// Holds widths, residue chain constants, reciprocals and shared types.
// No dependencies.
package sqd_pkg;

   localparam int IN_BITS  = 32;
   localparam int OUT_BITS = 24;
   localparam int SHIFT    = IN_BITS - OUT_BITS;

   localparam int NUM_STAGES = 5;
   localparam int STAGE_W    = 3;
   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

   localparam logic [31:0] MOD_A = 32'd170003;
   localparam logic [31:0] MOD_B = 32'd17011;
   localparam logic [31:0] MOD_C = 32'd1709;
   localparam logic [31:0] MOD_D = 32'd173;
   localparam logic [31:0] MOD_E = 32'd17;

   localparam logic [31:0] RECIP_A = 32'((64'd1 << 32) / 64'd170003);
   localparam logic [31:0] RECIP_B = 32'((64'd1 << 32) / 64'd17011);
   localparam logic [31:0] RECIP_C = 32'((64'd1 << 32) / 64'd1709);
   localparam logic [31:0] RECIP_D = 32'((64'd1 << 32) / 64'd173);
   localparam logic [31:0] RECIP_E = 32'((64'd1 << 32) / 64'd17);

   localparam logic [31:0] DITHER_PEAK   = 32'd16;
   localparam logic [31:0] COUNTER_RESET = 32'd99999999;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } mul_op_type;

   typedef struct packed {
      logic              done;
      logic signed [1:0] mag;
   } chain_res_type;

   function automatic logic [31:0] stage_mod(input logic [STAGE_W-1:0] idx);
      logic [31:0] m;
      unique case (idx)
         3'd0:    m = MOD_A;
         3'd1:    m = MOD_B;
         3'd2:    m = MOD_C;
         3'd3:    m = MOD_D;
         3'd4:    m = MOD_E;
         default: m = MOD_E;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] stage_recip(input logic [STAGE_W-1:0] idx);
      logic [31:0] r;
      unique case (idx)
         3'd0:    r = RECIP_A;
         3'd1:    r = RECIP_B;
         3'd2:    r = RECIP_C;
         3'd3:    r = RECIP_D;
         3'd4:    r = RECIP_E;
         default: r = RECIP_E;
      endcase
      return r;
   endfunction

endpackage

[rtl/sqd_mul.sv]
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on sqd_pkg.
module sqd_mul (
   input  logic               clock,
   input  sqd_pkg::mul_op_type op,
   output logic [63:0]        prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(op.a) * 64'(op.b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/sqd_seq.sv]
// Residue chain sequencer: square, then truncating remainder by constant, five times.
// Depends on sqd_pkg, sqd_mul and the assertion macro header.
`include "stereo_quadratic_dither_24bit_top_macros.svh"

module sqd_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            seed,
   output sqd_pkg::chain_res_type res
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_ABS  = 3'd2;
   localparam logic [2:0] ST_QEST = 3'd3;
   localparam logic [2:0] ST_QMUL = 3'd4;
   localparam logic [2:0] ST_REM  = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [sqd_pkg::STAGE_W-1:0] step_ff, step_in;
   logic [31:0]                 h_ff, h_in;
   logic [31:0]                 a_ff, a_in;
   logic                        neg_ff, neg_in;
   sqd_pkg::mul_op_type         op;
   logic [63:0]                 prod;
   logic [31:0]                 modv;
   logic [31:0]                 r_raw;
   logic [31:0]                 r_fix;

   sqd_mul u_mul (
      .clock (clock),
      .op    (op),
      .prod  (prod)
   );

   assign modv  = sqd_pkg::stage_mod(step_ff);
   assign r_raw = a_ff - prod[31:0];
   assign r_fix = (r_raw >= modv) ? (r_raw - modv) : r_raw;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      h_in     = h_ff;
      a_in     = a_ff;
      neg_in   = neg_ff;
      op.a     = h_ff;
      op.b     = h_ff;
      res.done = 1'b0;
      res.mag  = 2'sd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               h_in     = seed;
               step_in  = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = prod[31];
            a_in     = prod[31] ? (32'd0 - prod[31:0]) : prod[31:0];
            state_in = ST_QEST;
         end
         ST_QEST: begin
            op.a     = a_ff;
            op.b     = sqd_pkg::stage_recip(step_ff);
            state_in = ST_QMUL;
         end
         ST_QMUL: begin
            op.a     = prod[63:32];
            op.b     = modv;
            state_in = ST_REM;
         end
         ST_REM: begin
            h_in = neg_ff ? (32'd0 - r_fix) : r_fix;
            if (step_ff == sqd_pkg::LAST_STAGE) begin
               res.done = 1'b1;
               if (r_fix == sqd_pkg::DITHER_PEAK) begin
                  res.mag = neg_ff ? -2'sd1 : 2'sd1;
               end
               state_in = ST_IDLE;
            end else begin
               step_in  = step_ff + sqd_pkg::STAGE_W'(1);
               state_in = ST_SQ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      h_ff   <= h_in;
      a_ff   <= a_in;
      neg_ff <= neg_in;
   end

   `SQD_AST_SAME(a_rem_range, state_ff == ST_REM, r_fix < modv, "remainder not reduced")
   `SQD_AST_HOLD(a_step_range, step_ff <= sqd_pkg::LAST_STAGE, "stage index out of range")
   `SQD_AST_NEXT(a_done_idle, res.done, state_ff == ST_IDLE, "sequencer busy after done")
   `SQD_AST_HOLD(a_start_idle, !start || state_ff == ST_IDLE, "start while chain running")

endmodule

[rtl/sqd_requant.sv]
// One-channel requantizer: floor shift to output width, add dither, saturate.
// Depends on sqd_pkg.
module sqd_requant (
   input  logic signed [sqd_pkg::IN_BITS-1:0]  sample,
   input  logic signed [1:0]                   dither,
   output logic signed [sqd_pkg::OUT_BITS-1:0] result
);

   localparam int OW = sqd_pkg::OUT_BITS;
   localparam logic signed [OW:0] HI = (OW+1)'((64'd1 << (OW - 1)) - 64'd1);
   localparam logic signed [OW:0] LO = -HI - (OW+1)'(1);

   logic signed [sqd_pkg::IN_BITS-1:0] shifted;
   logic signed [OW:0]                 sum;

   assign shifted = sample >>> sqd_pkg::SHIFT;
   assign sum     = {shifted[OW-1], shifted[OW-1:0]} + {{(OW-1){dither[1]}}, dither};

   always_comb begin
      priority if (sum > HI) begin
         result = HI[OW-1:0];
      end else if (sum < LO) begin
         result = LO[OW-1:0];
      end else begin
         result = sum[OW-1:0];
      end
   end

endmodule

[rtl/stereo_quadratic_dither_24bit_top.sv]
// Top level of the stereo quadratic dither requantizer.
// Depends on sqd_pkg, sqd_seq, sqd_requant and the assertion macro header.
//
//   group  dir  tdata (low bit first)            meaning
//   req_   in   left_in[31:0], right_in[31:0]    one stereo frame, Q0.31
//   rsp_   out  left_out[23:0], right_out[23:0]  dithered 24-bit frame
//
// A frame passes through 5 stages of the residue chain, each one a square, an absolute value,
// a quotient estimate, a quotient multiply and a remainder step on the one shared multiplier;
// then its result is loaded into the output register and presented.
// A new frame is taken once the previous result has moved into the output register.
// Reset is synchronous and restores the frame counter and dither sign.
// A stalled result holds the output register; the chain waits until it frees.
`include "stereo_quadratic_dither_24bit_top_macros.svh"

module stereo_quadratic_dither_24bit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // left_in[31:0], right_in[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // left_out[23:0], right_out[47:24]
);

   logic                   busy_ff, busy_in;
   logic                   pend_ff, pend_in;
   logic signed [1:0]      dith_ff, dith_in;
   logic                   sign_ff, sign_in;
   logic [31:0]            counter_ff, counter_in;
   logic [31:0]            left_ff, right_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [47:0]            rsp_data_ff;
   logic                   req_xfer;
   logic                   load;
   logic signed [1:0]      dith_eff;
   logic [23:0]            left_q, right_q;
   sqd_pkg::chain_res_type res;

   assign req_tready = !busy_ff;
   assign req_xfer   = req_tvalid && !busy_ff;
   assign load       = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign dith_eff   = sign_ff ? -dith_ff : dith_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign counter_in = counter_ff + 32'd1;

   sqd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_xfer),
      .seed  (counter_in),
      .res   (res)
   );

   sqd_requant u_left (
      .sample (left_ff),
      .dither (dith_eff),
      .result (left_q)
   );

   sqd_requant u_right (
      .sample (right_ff),
      .dither (dith_eff),
      .result (right_q)
   );

   always_comb begin
      busy_in      = busy_ff;
      pend_in      = pend_ff;
      dith_in      = dith_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
      end
      if (res.done) begin
         pend_in = 1'b1;
         dith_in = res.mag;
      end
      if (load) begin
         pend_in      = 1'b0;
         busy_in      = 1'b0;
         sign_in      = !sign_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= sqd_pkg::COUNTER_RESET;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            counter_ff <= counter_in;
         end
      end
      dith_ff <= dith_in;
      if (req_xfer) begin
         left_ff  <= req_tdata[31:0];
         right_ff <= req_tdata[63:32];
      end
      if (load) begin
         rsp_data_ff <= {right_q, left_q};
      end
   end

   `SQD_AST_SAME(a_done_busy, res.done, busy_ff && !pend_ff, "chain done without a frame")
   `SQD_AST_NEXT(a_load_out, load, !busy_ff && rsp_valid_ff, "load did not fill output")
   `SQD_AST_NEXT(a_count_step, req_xfer, counter_ff == $past(counter_ff) + 32'd1, "counter skip")
   `SQD_AST_NEXT(a_sign_flip, load, sign_ff != $past(sign_ff), "dither sign did not alternate")

endmodule

[test/tb_stereo_quadratic_dither_24bit_top.sv]
// Self-checking bench for stereo_quadratic_dither_24bit_top: directed and random stereo frames,
// random stalls on both streams, results checked against a local dither/requantize predictor.
// Depends only on the RTL of the block.
`timescale 1ns / 1ps

module tb_stereo_quadratic_dither_24bit_top;

   localparam int N_DIR       = 20;
   localparam int N_RAND      = 1650;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 60;

   localparam int SAMPLE_SHIFT = 8;
   localparam int OUT_MAX      = 8388607;
   localparam int OUT_MIN      = -8388608;
   localparam int RES_MOD_1    = 170003;
   localparam int RES_MOD_2    = 17011;
   localparam int RES_MOD_3    = 1709;
   localparam int RES_MOD_4    = 173;
   localparam int RES_MOD_5    = 17;
   localparam int DITH_NUM     = 635;
   localparam int DITH_DEN     = 10000;
   localparam logic [31:0] POS_START = 32'd99999999;

   typedef struct packed {
      logic [23:0] right;
      logic [23:0] left;
   } out_frame_type;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
      logic        typed;
      logic [23:0] left_out;
      logic [23:0] right_out;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // left_in[31:0], right_in[63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // left_out[23:0], right_out[47:24]

   logic [31:0]   dither_pos = POS_START;
   logic          dither_neg = 1'b0;
   out_frame_type expected_frames[$];
   int            n_in      = 0;
   int            n_out     = 0;
   int            n_err     = 0;
   int            cycles    = 0;
   bit            held_long = 1'b0;

   stim_row_type dir_tab [N_DIR] = '{
      '{32'h7FFFFFFF, 32'h80000000, 1'b1, 24'h7FFFFF, 24'h800001},
      '{32'h80000000, 32'h7FFFFFFF, 1'b0, 24'h0, 24'h0},
      '{32'h00000000, 32'h00000000, 1'b0, 24'h0, 24'h0},
      '{32'hFFFFFFFF, 32'h00000001, 1'b0, 24'h0, 24'h0},
      '{32'h000000FF, 32'hFFFFFF00, 1'b0, 24'h0, 24'h0},
      '{32'h00000100, 32'hFFFFFEFF, 1'b0, 24'h0, 24'h0},
      '{32'h7FFFFF00, 32'h7FFFFEFF, 1'b0, 24'h0, 24'h0},
      '{32'h80000100, 32'h800000FF, 1'b0, 24'h0, 24'h0},
      '{32'hAAAAAAAA, 32'h55555555, 1'b0, 24'h0, 24'h0},
      '{32'h55555555, 32'hAAAAAAAA, 1'b0, 24'h0, 24'h0},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 24'h0, 24'h0},
      '{32'h80000000, 32'h80000000, 1'b0, 24'h0, 24'h0},
      '{32'h12345678, 32'hEDCBA988, 1'b0, 24'h0, 24'h0},
      '{32'h00800000, 32'hFF7FFFFF, 1'b0, 24'h0, 24'h0},
      '{32'h7FFFFFFF, 32'h80000000, 1'b0, 24'h0, 24'h0},
      '{32'h80000000, 32'h7FFFFFFF, 1'b0, 24'h0, 24'h0},
      '{32'h7FFFFFFF, 32'h80000000, 1'b0, 24'h0, 24'h0},
      '{32'h80000000, 32'h7FFFFFFF, 1'b0, 24'h0, 24'h0},
      '{32'h7FFFFF80, 32'h80000080, 1'b0, 24'h0, 24'h0},
      '{32'h00000000, 32'hFFFFFFFF, 1'b0, 24'h0, 24'h0}
   };

   stereo_quadratic_dither_24bit_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_stereo_quadratic_dither_24bit_top: done, errors");
         $finish;
      end
   end

   function automatic int residue_dither(input logic [31:0] pos);
      int h;
      h = pos * pos;
      h = h % RES_MOD_1;
      h = (h * h) % RES_MOD_2;
      h = (h * h) % RES_MOD_3;
      h = (h * h) % RES_MOD_4;
      h = (h * h) % RES_MOD_5;
      return (h * DITH_NUM) / DITH_DEN;
   endfunction

   function automatic logic [23:0] requantize(input logic signed [31:0] x, input int d);
      int v;
      v = x >>> SAMPLE_SHIFT;
      v = v + d;
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return v[23:0];
   endfunction

   // advance the frame position, requantize both channels, then flip the dither sign
   function automatic out_frame_type predict_dither_frame(input logic [31:0] l,
                                                          input logic [31:0] r);
      out_frame_type f;
      int d;
      dither_pos = dither_pos + 32'd1;
      d = residue_dither(dither_pos);
      if (dither_neg) d = -d;
      f.left  = requantize(l, d);
      f.right = requantize(r, d);
      dither_neg = ~dither_neg;
      return f;
   endfunction

   function automatic logic [31:0] pick_sample();
      logic [31:0] s;
      case ($urandom_range(0, 9))
         5: s = 32'h7FFFFFFF - $urandom_range(0, 1023);
         6: s = 32'h80000000 + $urandom_range(0, 1023);
         7: s = $urandom_range(0, 1023) - 512;
         8: begin
            case ($urandom_range(0, 3))
               0: s = 32'h7FFFFFFF;
               1: s = 32'h80000000;
               2: s = 32'h00000000;
               default: s = 32'hFFFFFFFF;
            endcase
         end
         9: s = $signed($urandom()) >>> $urandom_range(1, 31);
         default: s = $urandom();
      endcase
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin : scoreboard
      out_frame_type want;
      out_frame_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = predict_dither_frame(req_tdata[31:0], req_tdata[63:32]);
            if (n_in < N_DIR && dir_tab[n_in].typed) begin
               want.left  = dir_tab[n_in].left_out;
               want.right = dir_tab[n_in].right_out;
            end
            expected_frames.push_back(want);
            n_in = n_in + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            n_out = n_out + 1;
            if (expected_frames.size() == 0) begin
               $error("unexpected result transfer: left_out %h right_out %h",
                      got.left, got.right);
               n_err = n_err + 1;
            end else begin
               want = expected_frames.pop_front();
               if (got.left !== want.left) begin
                  $error("left_out: expected %h, actual %h", want.left, got.left);
                  n_err = n_err + 1;
               end
               if (got.right !== want.right) begin
                  $error("right_out: expected %h, actual %h", want.right, got.right);
                  n_err = n_err + 1;
               end
            end
         end
      end
   end

   initial begin : sink
      int gap;
      @(negedge reset);
      forever begin
         if (n_out >= 200 && !held_long) begin
            held_long = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!(n_out >= 600 && n_out < 800) && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin : source
      int n;
      int gap;
      logic [31:0] l;
      logic [31:0] r;
      @(negedge reset);
      @(posedge clock);
      for (n = 0; n < N_DIR + N_RAND; n++) begin
         if (n < N_DIR) begin
            l = dir_tab[n].left;
            r = dir_tab[n].right;
         end else begin
            l = pick_sample();
            r = pick_sample();
         end
         gap = (n >= 600 && n < 800) ? 0 : pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {r, l};
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_frames.size() != 0) begin
         $error("results still outstanding: %0d", expected_frames.size());
         n_err = n_err + 1;
      end
      if (n_err == 0) begin
         $display("tb_stereo_quadratic_dither_24bit_top: done, clean");
      end else begin
         $display("tb_stereo_quadratic_dither_24bit_top: done, errors");
      end
      $finish;
   end

endmodule
